/* rtl/mas_pkg.sv */
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types and constants for the 384-bit modular add/subtract unit.
// ----------------------------------------------------------------------------
package mas_pkg;

    // Port field widths
    localparam int OPCODE_W   = 3;
    localparam int LIMB_W     = 64;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_CFG    = 6;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_ADD = 3'd0;
    localparam t_opcode OP_SUB = 3'd1;
    localparam t_opcode OP_NEG = 3'd2;
    localparam t_opcode OP_SHL = 3'd3;
    localparam t_opcode OP_X3  = 3'd4;
    localparam t_opcode OP_X8  = 3'd5;

    // Operation header queued along with the operands
    typedef struct packed {
        t_opcode          op;
        logic [CNT_W-1:0] cnt;
        logic             flag;
    } t_cmd_hdr;

    localparam int HDR_W = $bits(t_cmd_hdr);

endpackage

/* rtl/mas_if.sv */
// ----------------------------------------------------------------------------
// mas_if
// Channel interfaces: operand limbs in, result limbs out, modulus writes.
// ----------------------------------------------------------------------------
interface mas_in_if
    import mas_pkg::*;
;
    logic                valid;
    logic                ready;
    t_opcode             opcode;
    logic [LIMB_W-1:0]   a_limb;
    logic [LIMB_W-1:0]   b_limb;
    logic [CNT_W-1:0]    shift_count;
    logic                neg_flag;
    logic                last_limb;

    modport source (output valid, opcode, a_limb, b_limb, shift_count, neg_flag,
                    last_limb, input ready);
    modport sink   (input valid, opcode, a_limb, b_limb, shift_count, neg_flag,
                    last_limb, output ready);
endinterface

interface mas_out_if
    import mas_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] r_limb;
    logic              last;

    modport source (output valid, r_limb, last, input ready);
    modport sink   (input valid, r_limb, last, output ready);
endinterface

interface mas_cfg_if
    import mas_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mas_front.sv */
// ----------------------------------------------------------------------------
// mas_front
// Collects operand limbs into the a/b stores and queues one command,
// with a snapshot of both operands, on every last limb.
// ----------------------------------------------------------------------------
module mas_front
    import mas_pkg::*;
#(
    parameter int LIMBS     = 6,
    parameter int LIMB_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mas_in_if.sink      i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output logic [HDR_W+2*LIMBS*LIMB_BITS-1:0] o_push_data
);

    localparam int IDX_W = $clog2(LIMBS);
    localparam logic [IDX_W-1:0] TOP = IDX_W'(LIMBS - 1);

    logic [LIMB_BITS-1:0]       r_a [LIMBS];
    logic [LIMB_BITS-1:0]       r_b [LIMBS];
    logic [IDX_W-1:0]           r_cnt;
    logic                       xfer;
    logic [LIMB_BITS-1:0]       a_in;
    logic [LIMB_BITS-1:0]       b_in;
    logic [LIMBS*LIMB_BITS-1:0] a_flat;
    logic [LIMBS*LIMB_BITS-1:0] b_flat;
    t_cmd_hdr                   hdr;

    assign i_in.ready = !i_q_full;
    assign xfer       = i_in.valid && !i_q_full;
    assign a_in       = i_in.a_limb[LIMB_BITS-1:0];
    assign b_in       = i_in.b_limb[LIMB_BITS-1:0];

    always_comb begin
        for (int k = 0; k < LIMBS; k++) begin
            a_flat[k*LIMB_BITS +: LIMB_BITS] = (k == LIMBS - 1) ? a_in : r_a[k];
            b_flat[k*LIMB_BITS +: LIMB_BITS] = (k == LIMBS - 1) ? b_in : r_b[k];
        end
        hdr.op   = i_in.opcode;
        hdr.cnt  = i_in.shift_count;
        hdr.flag = i_in.neg_flag;
    end

    assign o_push      = xfer && i_in.last_limb;
    assign o_push_data = {hdr, a_flat, b_flat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (xfer) begin
            if (i_in.last_limb) begin
                r_cnt <= '0;
            end else if (r_cnt != TOP) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Extra limbs past the top slot overwrite it
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            if (i_in.last_limb) begin
                r_a[LIMBS-1] <= a_in;
                r_b[LIMBS-1] <= b_in;
            end else begin
                r_a[r_cnt] <= a_in;
                r_b[r_cnt] <= b_in;
            end
        end
    end

endmodule

/* rtl/mas_cmd_queue.sv */
// ----------------------------------------------------------------------------
// mas_cmd_queue
// Short FIFO of queued commands between the front and the back.
// ----------------------------------------------------------------------------
module mas_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* rtl/mas_back.sv */
// ----------------------------------------------------------------------------
// mas_back
// Limb-serial modular engine: one add/subtract cell runs each modular pass
// one limb per cycle, then the result limbs stream out through a register.
// ----------------------------------------------------------------------------
module mas_back
    import mas_pkg::*;
#(
    parameter int LIMBS     = 6,
    parameter int LIMB_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mas_cfg_if.sink     i_cfg,
    input  logic        i_q_valid,
    input  logic [HDR_W+2*LIMBS*LIMB_BITS-1:0] i_q_data,
    output logic        o_q_pop,
    mas_out_if.source   o_res
);

    localparam int IDX_W  = $clog2(LIMBS);
    localparam int FLAT_W = LIMBS * LIMB_BITS;
    localparam logic [IDX_W-1:0] TOP = IDX_W'(LIMBS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_NEG = 2'd2;

    localparam logic [1:0] Y_X = 2'd0;
    localparam logic [1:0] Y_A = 2'd1;
    localparam logic [1:0] Y_B = 2'd2;

    logic [LIMB_BITS-1:0] r_mod [LIMBS];
    logic [LIMB_BITS-1:0] r_a   [LIMBS];
    logic [LIMB_BITS-1:0] r_b   [LIMBS];
    logic [LIMB_BITS-1:0] r_p   [LIMBS];
    logic [LIMB_BITS-1:0] r_q   [LIMBS];

    logic [1:0]       r_state;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_passes;
    t_opcode          r_op;
    logic             r_flag;
    logic             r_use_q;
    logic             r_c1;
    logic             r_c2;
    logic             r_any;
    logic             r_o_valid;
    logic             r_o_last;
    logic [LIMB_W-1:0] r_o_limb;

    t_cmd_hdr             hdr;
    logic [FLAT_W-1:0]    a_flat;
    logic [FLAT_W-1:0]    b_flat;
    logic [CNT_W-1:0]     pass_cnt;
    logic [1:0]           mode;
    logic [1:0]           ysel;
    logic [LIMB_BITS-1:0] x;
    logic [LIMB_BITS-1:0] y;
    logic [LIMB_BITS-1:0] m;
    logic [LIMB_BITS-1:0] n_p;
    logic [LIMB_BITS-1:0] n_q;
    logic                 n_c1;
    logic                 n_c2;
    logic                 n_any;
    logic                 n_use_q;
    logic [LIMB_BITS:0]   stage1;
    logic [LIMB_BITS:0]   stage2;
    logic                 out_load;
    logic                 pass_end;

    assign hdr    = i_q_data[HDR_W+2*FLAT_W-1 -: HDR_W];
    assign a_flat = i_q_data[2*FLAT_W-1 -: FLAT_W];
    assign b_flat = i_q_data[FLAT_W-1:0];

    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign out_load = !r_o_valid || o_res.ready;
    assign pass_end = (r_idx == TOP);

    assign i_cfg.ready  = 1'b1;
    assign o_res.valid  = r_o_valid;
    assign o_res.r_limb = r_o_limb;
    assign o_res.last   = r_o_last;

    // Number of modular passes for the queued command
    always_comb begin
        case (hdr.op)
            OP_ADD, OP_SUB, OP_NEG: pass_cnt = CNT_W'(1);
            OP_SHL:                 pass_cnt = hdr.cnt;
            OP_X3:                  pass_cnt = CNT_W'(2);
            OP_X8:                  pass_cnt = CNT_W'(3);
            default:                pass_cnt = '0;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_SUB:  mode = MODE_SUB;
            OP_NEG:  mode = MODE_NEG;
            default: mode = MODE_ADD;
        endcase
        case (r_op)
            OP_ADD, OP_SUB: ysel = Y_B;
            OP_X3:          ysel = (r_passes == CNT_W'(1)) ? Y_A : Y_X;
            default:        ysel = Y_X;
        endcase
    end

    // Limb cell: first chain forms P, second chain folds in the modulus
    always_comb begin
        x = r_use_q ? r_q[0] : r_p[0];
        m = r_mod[r_idx];
        case (ysel)
            Y_A:     y = r_a[0];
            Y_B:     y = r_b[0];
            default: y = x;
        endcase
        stage1  = '0;
        stage2  = '0;
        n_any   = r_any | (|x);
        n_use_q = 1'b0;
        case (mode)
            MODE_SUB: begin
                stage1  = {1'b0, x} - {1'b0, y} - {{LIMB_BITS{1'b0}}, r_c1};
                stage2  = {1'b0, stage1[LIMB_BITS-1:0]} + {1'b0, m}
                          + {{LIMB_BITS{1'b0}}, r_c2};
                n_use_q = stage1[LIMB_BITS];
            end
            MODE_NEG: begin
                stage1  = {1'b0, x};
                stage2  = {1'b0, m} - {1'b0, x} - {{LIMB_BITS{1'b0}}, r_c2};
                n_use_q = r_flag & n_any;
            end
            default: begin
                stage1  = {1'b0, x} + {1'b0, y} + {{LIMB_BITS{1'b0}}, r_c1};
                stage2  = {1'b0, stage1[LIMB_BITS-1:0]} - {1'b0, m}
                          - {{LIMB_BITS{1'b0}}, r_c2};
                // keep the plain sum only when it is below the modulus
                n_use_q = !stage2[LIMB_BITS] || stage1[LIMB_BITS];
            end
        endcase
        n_p  = stage1[LIMB_BITS-1:0];
        n_q  = stage2[LIMB_BITS-1:0];
        n_c1 = stage1[LIMB_BITS];
        n_c2 = stage2[LIMB_BITS];
    end

    // Modulus registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LIMBS; j++) begin
                r_mod[j] <= '0;
            end
        end else if (i_cfg.valid) begin
            for (int j = 0; j < LIMBS; j++) begin
                if (j < NUM_CFG && i_cfg.index == CFG_IDX_W'(j)) begin
                    r_mod[j] <= i_cfg.data[LIMB_BITS-1:0];
                end
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_passes  <= '0;
            r_op      <= OP_ADD;
            r_flag    <= 1'b0;
            r_use_q   <= 1'b0;
            r_c1      <= 1'b0;
            r_c2      <= 1'b0;
            r_any     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_op     <= hdr.op;
                        r_flag   <= hdr.flag;
                        r_passes <= pass_cnt;
                        r_use_q  <= 1'b0;
                        r_idx    <= '0;
                        r_c1     <= 1'b0;
                        r_c2     <= 1'b0;
                        r_any    <= 1'b0;
                        r_state  <= (pass_cnt == '0) ? ST_OUT : ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (pass_end) begin
                        r_idx    <= '0;
                        r_c1     <= 1'b0;
                        r_c2     <= 1'b0;
                        r_any    <= 1'b0;
                        r_use_q  <= n_use_q;
                        r_passes <= r_passes - 1'b1;
                        if (r_passes == CNT_W'(1)) begin
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_c1  <= n_c1;
                        r_c2  <= n_c2;
                        r_any <= n_any;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (pass_end) begin
                            r_idx   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (r_state == ST_OUT && out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath: operands and working value rotate through index 0
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    for (int k = 0; k < LIMBS; k++) begin
                        r_a[k] <= a_flat[k*LIMB_BITS +: LIMB_BITS];
                        r_b[k] <= b_flat[k*LIMB_BITS +: LIMB_BITS];
                        r_p[k] <= a_flat[k*LIMB_BITS +: LIMB_BITS];
                    end
                end
            end
            ST_RUN: begin
                for (int k = 0; k < LIMBS - 1; k++) begin
                    r_a[k] <= r_a[k+1];
                    r_b[k] <= r_b[k+1];
                    r_p[k] <= r_p[k+1];
                    r_q[k] <= r_q[k+1];
                end
                r_a[LIMBS-1] <= r_a[0];
                r_b[LIMBS-1] <= r_b[0];
                r_p[LIMBS-1] <= n_p;
                r_q[LIMBS-1] <= n_q;
            end
            ST_OUT: begin
                if (out_load) begin
                    for (int k = 0; k < LIMBS - 1; k++) begin
                        r_p[k] <= r_p[k+1];
                        r_q[k] <= r_q[k+1];
                    end
                    r_p[LIMBS-1] <= r_p[0];
                    r_q[LIMBS-1] <= r_q[0];
                    r_o_limb     <= LIMB_W'(x);
                    r_o_last     <= pass_end;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/modular_add_sub_384.sv */
// ----------------------------------------------------------------------------
// modular_add_sub_384
// Modular add, subtract, conditional negate, left shift by doubling, times
// three and times eight over a modulus held in configuration registers.
//
//  port     dir  flow                    payload
//  i_in     in   operand limbs, LSB 1st  opcode, a_limb, b_limb,
//                                        shift_count, neg_flag, last_limb
//  o_res    out  result limbs, LSB 1st   r_limb, last
//  i_cfg    in   modulus writes          index 0..5, data
//
// Operand limbs transfer one per cycle while the command queue has room.
// The back loads a command, runs N modular passes over the limbs and then
// streams the result limbs out; N is 1 for add/sub/negate, 2 for times
// three, 3 for times eight, shift_count for left shift and 0 otherwise.
// One limb-serial add/subtract cell runs every pass.
// Reset is synchronous, active low; o_res stalls hold the back, then i_in.
// ----------------------------------------------------------------------------
module modular_add_sub_384
    import mas_pkg::*;
#(
    parameter int LIMBS     = 6,
    parameter int LIMB_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mas_in_if.sink    i_in,
    mas_out_if.source o_res,
    mas_cfg_if.sink   i_cfg
);

    localparam int Q_W = HDR_W + 2 * LIMBS * LIMB_BITS;

    logic           q_push;
    logic [Q_W-1:0] q_push_data;
    logic           q_pop;
    logic           q_full;
    logic           q_valid;
    logic [Q_W-1:0] q_data;

    mas_front #(
        .LIMBS     (LIMBS),
        .LIMB_BITS (LIMB_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    mas_cmd_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    mas_back #(
        .LIMBS     (LIMBS),
        .LIMB_BITS (LIMB_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_full_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> q_valid)
        else $error("queue full but no command visible");

endmodule
